@@ hw/rtl/hsfd_pkg.sv @@
package hsfd_pkg;

  // One received reply byte and its frame marker.
  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_start;
  } in_t;

  // One decoded frame.
  typedef struct packed {
    logic signed [14:0] temperature_centi;
    logic [13:0]        humidity_centi;
    logic               status;
  } out_t;

  // A fully received frame, handed from the byte front end to the converter.
  typedef struct packed {
    logic [15:0] temp_word;
    logic [15:0] hum_word;
    logic        fail;
  } job_t;

  // Byte positions within a reply frame.
  localparam logic [2:0] POS_T_MSB = 3'd0;
  localparam logic [2:0] POS_T_LSB = 3'd1;
  localparam logic [2:0] POS_T_CRC = 3'd2;
  localparam logic [2:0] POS_H_MSB = 3'd3;
  localparam logic [2:0] POS_H_LSB = 3'd4;
  localparam logic [2:0] POS_H_CRC = 3'd5;

  localparam logic [7:0] CRC_INIT = 8'hFF;
  localparam logic [7:0] CRC_POLY = 8'h31;

  localparam int JOB_DEPTH = 4;
  localparam int JOB_AW    = $clog2(JOB_DEPTH);
  localparam int JOB_CW    = $clog2(JOB_DEPTH + 1);

  localparam logic [14:0] TEMP_SCALE  = 15'd17500;
  localparam logic [13:0] HUM_SCALE   = 14'd10000;
  localparam logic [14:0] TEMP_OFFSET = 15'd4500;

  // CRC-8, MSB first, one byte folded in.
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

@@ hw/rtl/hsfd_front.sv @@
module hsfd_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_push,
  input  hsfd_pkg::in_t in_data,
  input  logic          job_full,
  output logic          job_push,
  output hsfd_pkg::job_t job_data
);
  import hsfd_pkg::*;

  logic [2:0]  byte_idx_r, byte_idx_nxt;
  logic [7:0]  crc_r, crc_nxt;
  logic [15:0] temp_word_r, temp_word_nxt;
  logic [15:0] hum_word_r, hum_word_nxt;
  logic        temp_fail_r, temp_fail_nxt;
  logic        take;
  logic [2:0]  pos;
  logic [7:0]  crc_seed;
  logic [7:0]  crc_upd;

  assign take     = in_push && !job_full;
  assign pos      = (in_data.frame_start || byte_idx_r > POS_H_CRC) ? POS_T_MSB : byte_idx_r;
  assign crc_seed = (pos == POS_T_MSB || pos == POS_H_MSB) ? CRC_INIT : crc_r;
  assign crc_upd  = crc8_byte(crc_seed, in_data.rx_byte);

  always_comb begin
    byte_idx_nxt  = byte_idx_r;
    crc_nxt       = crc_r;
    temp_word_nxt = temp_word_r;
    hum_word_nxt  = hum_word_r;
    temp_fail_nxt = temp_fail_r;
    job_push      = 1'b0;
    job_data      = '{temp_word: temp_word_r, hum_word: hum_word_r,
                      fail: temp_fail_r || (crc_r != in_data.rx_byte)};
    if (take) begin
      case (pos)
        POS_T_MSB: begin
          temp_fail_nxt = 1'b0;
          crc_nxt       = crc_upd;
          temp_word_nxt = {in_data.rx_byte, 8'h00};
          byte_idx_nxt  = POS_T_LSB;
        end
        POS_T_LSB: begin
          crc_nxt       = crc_upd;
          temp_word_nxt = {temp_word_r[15:8], in_data.rx_byte};
          byte_idx_nxt  = POS_T_CRC;
        end
        POS_T_CRC: begin
          temp_fail_nxt = (crc_r != in_data.rx_byte);
          crc_nxt       = CRC_INIT;
          byte_idx_nxt  = POS_H_MSB;
        end
        POS_H_MSB: begin
          crc_nxt      = crc_upd;
          hum_word_nxt = {in_data.rx_byte, 8'h00};
          byte_idx_nxt = POS_H_LSB;
        end
        POS_H_LSB: begin
          crc_nxt      = crc_upd;
          hum_word_nxt = {hum_word_r[15:8], in_data.rx_byte};
          byte_idx_nxt = POS_H_CRC;
        end
        default: begin
          job_push      = 1'b1;
          crc_nxt       = CRC_INIT;
          temp_fail_nxt = 1'b0;
          byte_idx_nxt  = POS_T_MSB;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_idx_r  <= POS_T_MSB;
      crc_r       <= CRC_INIT;
      temp_word_r <= '0;
      hum_word_r  <= '0;
      temp_fail_r <= 1'b0;
    end else begin
      byte_idx_r  <= byte_idx_nxt;
      crc_r       <= crc_nxt;
      temp_word_r <= temp_word_nxt;
      hum_word_r  <= hum_word_nxt;
      temp_fail_r <= temp_fail_nxt;
    end
  end

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    byte_idx_r <= POS_H_CRC)
    else $error("byte position left the frame range");

  a_push_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    job_push |=> (byte_idx_r == POS_T_MSB && crc_r == CRC_INIT && !temp_fail_r))
    else $error("frame end did not restart the byte state");

endmodule

@@ hw/rtl/hsfd_job_fifo.sv @@
module hsfd_job_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  hsfd_pkg::job_t push_data,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output hsfd_pkg::job_t pop_data
);
  import hsfd_pkg::*;

  job_t              mem [JOB_DEPTH];
  logic [JOB_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [JOB_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [JOB_CW-1:0] count_r, count_nxt;
  logic              do_push, do_pop;

  assign full     = (count_r == JOB_CW'(JOB_DEPTH));
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= JOB_CW'(JOB_DEPTH))
    else $error("job queue count overflow");

  a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
    (do_push && !do_pop) |=> (count_r == $past(count_r) + 1'b1))
    else $error("job queue count missed a push");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_ptr_r - rd_ptr_r) == count_r[JOB_AW-1:0])
    else $error("job queue pointers disagree with count");

endmodule

@@ hw/rtl/hsfd_back.sv @@
module hsfd_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           job_empty,
  input  hsfd_pkg::job_t job_data,
  output logic           job_pop,
  input  logic           out_pop,
  output logic           out_empty,
  output hsfd_pkg::out_t out_data
);
  import hsfd_pkg::*;

  // floor(x / 65535) for x < 2^31: estimate by x >> 16, then one correction.
  function automatic logic [14:0] div65535(input logic [30:0] x);
    logic [14:0] q0;
    logic [16:0] r;
    q0 = x[30:16];
    r  = {1'b0, x[15:0]} + {2'b00, q0};
    return (r >= 17'd65535) ? q0 + 15'd1 : q0;
  endfunction

  logic        adv;
  logic        s1_valid_r, s1_valid_nxt;
  logic [30:0] t_prod_r, t_prod_nxt;
  logic [29:0] h_prod_r, h_prod_nxt;
  logic        s1_fail_r, s1_fail_nxt;
  logic        out_valid_r, out_valid_nxt;
  out_t        out_r, out_nxt;
  logic [14:0] t_quot;
  logic [14:0] h_quot;

  // The whole converter moves together whenever the output slot frees up.
  assign adv     = !out_valid_r || out_pop;
  assign job_pop = adv && !job_empty;

  assign t_prod_nxt   = TEMP_SCALE * job_data.temp_word;
  assign h_prod_nxt   = HUM_SCALE * job_data.hum_word;
  assign s1_fail_nxt  = job_data.fail;
  assign s1_valid_nxt = adv ? !job_empty : s1_valid_r;

  assign t_quot = div65535(t_prod_r);
  assign h_quot = div65535({1'b0, h_prod_r});

  always_comb begin
    out_valid_nxt = adv ? s1_valid_r : out_valid_r;
    out_nxt       = out_r;
    if (adv) begin
      if (s1_fail_r) begin
        out_nxt = '{temperature_centi: '0, humidity_centi: '0, status: 1'b1};
      end else begin
        out_nxt = '{temperature_centi: $signed(t_quot - TEMP_OFFSET),
                    humidity_centi: h_quot[13:0], status: 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      t_prod_r  <= t_prod_nxt;
      h_prod_r  <= h_prod_nxt;
      s1_fail_r <= s1_fail_nxt;
    end
    out_r <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_empty = !out_valid_r;
  assign out_data  = out_r;

endmodule

@@ hw/rtl/humidity_sensor_frame_decode_core.sv @@
// Frame decoder for a six-byte temperature/humidity sensor reply.
//
// Input channel: one reply byte per beat, pushed with in_push while in_full
// is low, in the order T_MSB, T_LSB, T_CRC, H_MSB, H_LSB, H_CRC. Setting
// frame_start on a beat makes that byte the first of a new frame and drops
// any partly received frame. Each word is checked with CRC-8 (poly 0x31,
// init 0xFF, MSB first).
//
// Result channel: one beat per complete frame, read like a queue with
// out_pop while out_empty is low. Temperature is in hundredths of a degree C,
// humidity in hundredths of a percent; on any CRC mismatch status is 1 and
// both values read 0.
//
// Timing: one byte per cycle is accepted while in_full is low. The last byte
// of a frame puts the frame into the job queue; from there it passes one
// multiply stage, then the output register. The scaling by 1/65535 needs no
// divider; a shift estimate plus a single compare-and-add gives the floor.
//
// When the reader stalls, finished frames pile up in a four-entry job queue
// between the byte front end and the converter; in_full rises only when that
// queue is full. Reset (synchronous, rst_n low) empties the queue and the
// output and starts the byte count at the first temperature byte.
module humidity_sensor_frame_decode_core (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_push,
  output logic            in_full,
  input  hsfd_pkg::in_t   in_data,
  input  logic            out_pop,
  output logic            out_empty,
  output hsfd_pkg::out_t  out_data
);
  import hsfd_pkg::*;

  logic job_push;
  logic job_full;
  logic job_pop;
  logic job_empty;
  job_t job_in;
  job_t job_out;

  // Byte handling stalls only on a full job queue.
  assign in_full = job_full;

  hsfd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_data  (in_data),
    .job_full (job_full),
    .job_push (job_push),
    .job_data (job_in)
  );

  hsfd_job_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (job_push),
    .push_data (job_in),
    .full      (job_full),
    .pop       (job_pop),
    .empty     (job_empty),
    .pop_data  (job_out)
  );

  hsfd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_empty (job_empty),
    .job_data  (job_out),
    .job_pop   (job_pop),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .out_data  (out_data)
  );

endmodule

@@ tb/sv/hsfd_frame_checker.sv @@
`timescale 1ns / 1ps

module hsfd_frame_checker (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_push,
  input  logic            in_full,
  input  hsfd_pkg::in_t   in_data,
  input  logic            out_pop,
  input  logic            out_empty,
  input  hsfd_pkg::out_t  out_data,
  output int unsigned     mismatch_count,
  output int unsigned     frames_outstanding,
  output int unsigned     frames_checked,
  output int unsigned     frames_rejected
);
  import hsfd_pkg::*;

  // Decoder state, as the block holds it.
  logic [2:0]  frame_pos;
  logic [7:0]  word_crc;
  logic [15:0] temp_raw;
  logic [15:0] hum_raw;
  logic        temp_crc_bad;

  out_t        decoded_frames[$];
  int unsigned n_mismatch;
  int unsigned n_checked;
  int unsigned n_rejected;

  function automatic logic [7:0] crc8_fold(input logic [7:0] acc, input logic [7:0] data);
    logic [7:0] r;
    r = acc ^ data;
    for (int k = 0; k < 8; k++) begin
      r = r[7] ? ({r[6:0], 1'b0} ^ CRC_POLY) : {r[6:0], 1'b0};
    end
    return r;
  endfunction

  // Scale the raw words by floor division; both values read zero on a bad checksum.
  function automatic out_t convert_frame(input logic [15:0] t, input logic [15:0] h,
                                         input logic bad);
    out_t        r;
    int unsigned tq;
    int unsigned hq;
    r = '0;
    r.status = bad;
    if (!bad) begin
      tq = (32'd17500 * 32'(t)) / 32'd65535;
      hq = (32'd10000 * 32'(h)) / 32'd65535;
      r.temperature_centi = 15'(tq - 32'd4500);
      r.humidity_centi    = 14'(hq);
    end
    return r;
  endfunction

  always @(posedge clk) begin
    logic [2:0] pos;
    logic       bad;
    out_t       want;
    if (!rst_n) begin
      frame_pos    = POS_T_MSB;
      word_crc     = CRC_INIT;
      temp_raw     = '0;
      hum_raw      = '0;
      temp_crc_bad = 1'b0;
      decoded_frames.delete();
      n_mismatch   = 0;
      n_checked    = 0;
      n_rejected   = 0;
    end else begin
      if (out_pop && !out_empty) begin
        if (decoded_frames.size() == 0) begin
          $error("result beat with no frame expected: temperature_centi %0d",
                 out_data.temperature_centi);
          n_mismatch++;
        end else begin
          want = decoded_frames.pop_front();
          n_checked++;
          if (want.status) n_rejected++;
          if (out_data.temperature_centi !== want.temperature_centi) begin
            $error("temperature_centi: expected %0d, got %0d",
                   want.temperature_centi, out_data.temperature_centi);
            n_mismatch++;
          end
          if (out_data.humidity_centi !== want.humidity_centi) begin
            $error("humidity_centi: expected %0d, got %0d",
                   want.humidity_centi, out_data.humidity_centi);
            n_mismatch++;
          end
          if (out_data.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_data.status);
            n_mismatch++;
          end
        end
      end

      if (in_push && !in_full) begin
        pos = frame_pos;
        if (in_data.frame_start || pos > POS_H_CRC) pos = POS_T_MSB;
        case (pos)
          POS_T_MSB: begin
            temp_crc_bad = 1'b0;
            word_crc     = crc8_fold(CRC_INIT, in_data.rx_byte);
            temp_raw     = {in_data.rx_byte, 8'h00};
            frame_pos    = POS_T_LSB;
          end
          POS_T_LSB: begin
            word_crc      = crc8_fold(word_crc, in_data.rx_byte);
            temp_raw[7:0] = in_data.rx_byte;
            frame_pos     = POS_T_CRC;
          end
          POS_T_CRC: begin
            temp_crc_bad = (word_crc != in_data.rx_byte);
            word_crc     = CRC_INIT;
            frame_pos    = POS_H_MSB;
          end
          POS_H_MSB: begin
            word_crc  = crc8_fold(CRC_INIT, in_data.rx_byte);
            hum_raw   = {in_data.rx_byte, 8'h00};
            frame_pos = POS_H_LSB;
          end
          POS_H_LSB: begin
            word_crc     = crc8_fold(word_crc, in_data.rx_byte);
            hum_raw[7:0] = in_data.rx_byte;
            frame_pos    = POS_H_CRC;
          end
          default: begin
            bad = temp_crc_bad || (word_crc != in_data.rx_byte);
            decoded_frames.push_back(convert_frame(temp_raw, hum_raw, bad));
            frame_pos    = POS_T_MSB;
            word_crc     = CRC_INIT;
            temp_crc_bad = 1'b0;
          end
        endcase
      end
    end
    mismatch_count     <= n_mismatch;
    frames_outstanding <= decoded_frames.size();
    frames_checked     <= n_checked;
    frames_rejected    <= n_rejected;
  end

endmodule

@@ tb/sv/humidity_sensor_frame_decode_core_test.sv @@
`timescale 1ns / 1ps

module humidity_sensor_frame_decode_core_test;
  import hsfd_pkg::*;

  // Roughly how many input beats the random part sends.
  localparam int unsigned RANDOM_BYTES = 400;
  // Cycles with no beat on either side before the run is declared hung. The
  // worst honest pause is a sender gap plus a reader gap plus the pipeline,
  // so this is many times over.
  localparam int unsigned HANG_LIMIT   = 1000;
  // Quiet cycles at the end so that a stray extra result would still show up.
  localparam int unsigned DRAIN_CYCLES = 20;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic in_push  = 1'b0;
  logic in_full;
  in_t  in_data  = '0;
  logic out_pop  = 1'b0;
  logic out_empty;
  out_t out_data;

  int unsigned mismatch_count;
  int unsigned frames_outstanding;
  int unsigned frames_checked;
  int unsigned frames_rejected;

  // Sender and reader each switch between random gaps and back-to-back runs.
  logic        send_burst = 1'b0;
  logic        recv_burst = 1'b0;
  int unsigned bytes_sent = 0;
  int unsigned frames_sent = 0;
  int unsigned idle_cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  humidity_sensor_frame_decode_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_data   (in_data),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .out_data  (out_data)
  );

  hsfd_frame_checker u_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_push            (in_push),
    .in_full            (in_full),
    .in_data            (in_data),
    .out_pop            (out_pop),
    .out_empty          (out_empty),
    .out_data           (out_data),
    .mismatch_count     (mismatch_count),
    .frames_outstanding (frames_outstanding),
    .frames_checked     (frames_checked),
    .frames_rejected    (frames_rejected)
  );

  // The sensor's checksum over one 16-bit word, used to build legal frames.
  function automatic logic [7:0] word_checksum(input logic [15:0] word);
    logic [7:0] c;
    c = CRC_INIT;
    for (int k = 15; k >= 0; k--) begin
      c = (c[7] ^ word[k]) ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

  // Send one reply byte. The gap is drawn first, then push is held until the
  // beat goes through. When the gap is zero, push simply stays high from the
  // previous beat, so it is never dropped and raised within one time step.
  task automatic push_byte(input logic [7:0] value, input logic start);
    int unsigned gap;
    gap = send_burst ? 0 : $urandom_range(0, 16);
    if (gap != 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_push             <= 1'b1;
    in_data.rx_byte     <= value;
    in_data.frame_start <= start;
    @(posedge clk);
    while (in_full) @(posedge clk);
    bytes_sent++;
  endtask

  // A whole six-byte reply. A cleared ok flag corrupts that word's checksum
  // by a nonzero pattern, so the mismatch is certain.
  task automatic send_frame(input logic [15:0] temp_word, input logic [15:0] hum_word,
                            input logic start, input logic temp_ok, input logic hum_ok);
    logic [7:0] temp_crc;
    logic [7:0] hum_crc;
    temp_crc = word_checksum(temp_word);
    hum_crc  = word_checksum(hum_word);
    if (!temp_ok) temp_crc ^= 8'($urandom_range(1, 255));
    if (!hum_ok)  hum_crc  ^= 8'($urandom_range(1, 255));
    push_byte(temp_word[15:8], start);
    push_byte(temp_word[7:0], 1'b0);
    push_byte(temp_crc, 1'b0);
    push_byte(hum_word[15:8], 1'b0);
    push_byte(hum_word[7:0], 1'b0);
    push_byte(hum_crc, 1'b0);
    frames_sent++;
  endtask

  // Raw sensor words, leaning toward the ends of the scale where the
  // floor division and the temperature offset are most likely to slip.
  function automatic logic [15:0] pick_word();
    case ($urandom_range(0, 7))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'($urandom_range(0, 15));
      3:       return 16'hFFFF - 16'($urandom_range(0, 15));
      default: return 16'($urandom);
    endcase
  endfunction

  // The reader: pops one result per draw, after its own random wait.
  initial begin
    int unsigned gap;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      gap = recv_burst ? 0 : $urandom_range(0, 16);
      if (gap != 0) begin
        out_pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_pop <= 1'b1;
      @(posedge clk);
      while (out_empty) @(posedge clk);
      if ($urandom_range(0, 7) == 0) recv_burst = !recv_burst;
    end
  end

  // Watchdog: any beat on either side proves the block is still moving.
  always @(posedge clk) begin
    if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles + 1 >= HANG_LIMIT) begin
        $display("timeout: %0d cycles without a beat, %0d frames still expected",
                 HANG_LIMIT, frames_outstanding);
        $display("humidity_sensor_frame_decode_core_test failed");
        $finish;
      end
    end
  end

  initial begin
    int unsigned n;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed frames. The first is the bottom of both scales. The second
    // is the top of both scales sent without the start marker, so it must
    // be framed by the byte count alone. Then a two-byte fragment is cut
    // off by a restart, and the restarted frame carries a bad temperature
    // checksum. Last comes a bad humidity checksum on its own.
    send_frame(16'h0000, 16'h0000, 1'b1, 1'b1, 1'b1);
    send_frame(16'hFFFF, 16'hFFFF, 1'b0, 1'b1, 1'b1);
    push_byte(8'h12, 1'b1);
    push_byte(8'h34, 1'b0);
    send_frame(16'h6666, 16'h8000, 1'b1, 1'b0, 1'b1);
    send_frame(16'h5A3C, 16'hA5C3, 1'b1, 1'b1, 1'b0);

    // Random part: mostly legal frames with random words and an occasional
    // bad checksum, mixed with fragments cut off by a restart and with raw
    // noise whose start markers land anywhere in the byte count.
    while (bytes_sent < RANDOM_BYTES + 26) begin
      send_burst = ($urandom_range(0, 4) == 0);
      case ($urandom_range(0, 9))
        0: begin
          n = $urandom_range(1, 5);
          repeat (n) push_byte(8'($urandom), ($urandom_range(0, 3) == 0));
        end
        1: begin
          n = $urandom_range(1, 5);
          push_byte(8'($urandom), 1'b1);
          repeat (n - 1) push_byte(8'($urandom), 1'b0);
        end
        default: begin
          send_frame(pick_word(), pick_word(), ($urandom_range(0, 3) != 0),
                     ($urandom_range(0, 7) != 0), ($urandom_range(0, 7) != 0));
        end
      endcase
    end
    in_push <= 1'b0;

    // Wait for the clock so the last accepted beat is reflected in the checker's count.
    @(posedge clk);
    while (frames_outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d bytes in %0d complete frames plus fragments and noise",
             bytes_sent, frames_sent);
    $display("checked %0d decoded frames, %0d of them flagged with a checksum error",
             frames_checked, frames_rejected);
    if (mismatch_count == 0) begin
      $display("humidity_sensor_frame_decode_core_test passed");
    end else begin
      $display("humidity_sensor_frame_decode_core_test failed");
    end
    $finish;
  end

endmodule
